@@ hw/rtl/moesif_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package moesif_pkg;

   localparam int OP_W      = 3;
   localparam int LINE_IN_W = 8;
   localparam int ADDR_W    = 32;
   localparam int RID_W     = 4;
   localparam int STATE_W   = 4;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 3'd0,
      OP_STORE = 3'd1,
      OP_GETS  = 3'd2,
      OP_GETM  = 3'd3,
      OP_DATA  = 3'd4
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      ST_I  = 4'd0,
      ST_S  = 4'd1,
      ST_E  = 4'd2,
      ST_O  = 4'd3,
      ST_M  = 4'd4,
      ST_F  = 4'd5,
      ST_IS = 4'd6,
      ST_IM = 4'd7,
      ST_SM = 4'd8,
      ST_OM = 4'd9,
      ST_FM = 4'd10
   } line_state_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_UNEXPECTED  = 2'd1,
      ERR_OUTSTANDING = 2'd2,
      ERR_DATA_OWNED  = 2'd3
   } err_type;

   typedef struct packed {
      logic              issue_gets;
      logic              issue_getm;
      logic              data_to_cpu;
      logic              data_to_bus;
      logic [RID_W-1:0]  data_dest_id;
      logic              shared_out;
      logic [ADDR_W-1:0] address_out;
      logic              miss_event;
      logic              silent_upgrade_event;
      err_type           error_code;
   } rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/moesif_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module moesif_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  wire                                        clock,
   input  wire                                        wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                           wr_data,
   input  wire                                        rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/moesif_line_coherence_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none

// The line-state RAM is read at accept and the request held in the s1 register; on advance the
// new state is written back and the response registered (rsp_valid). Throughput: one request per
// cycle unless a stalled response blocks s1; the line-state RAM has one read and one write port,
// and a write-to-read bypass covers back-to-back requests to the same line. Reset: synchronous;
// afterwards a clearing sweep sets every line to I, during which req_stall stays high.
module moesif_line_coherence_fsm
   import moesif_pkg::*;
#(
   parameter int NUM_LINES = 256,
   parameter int ADDR_BITS = 32
) (
   input  wire                clock,
   input  wire                reset,

   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [OP_W-1:0]    req_operation,
   input  wire  [LINE_IN_W-1:0] req_line_index,
   input  wire  [ADDR_W-1:0]  req_address,
   input  wire  [RID_W-1:0]   req_requester_id,
   input  wire                req_shared_in,

   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_issue_gets,
   output logic               rsp_issue_getm,
   output logic               rsp_data_to_cpu,
   output logic               rsp_data_to_bus,
   output logic [RID_W-1:0]   rsp_data_dest_id,
   output logic               rsp_shared_out,
   output logic [ADDR_W-1:0]  rsp_address_out,
   output logic               rsp_miss_event,
   output logic               rsp_silent_upgrade_event,
   output logic [1:0]         rsp_error_code
);

   localparam int LINE_IDX_BITS = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int ADDR_KEEP     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [LINE_IDX_BITS:0]   NUM_LINES_R = (LINE_IDX_BITS + 1)'(NUM_LINES);
   localparam logic [LINE_IDX_BITS-1:0] LAST_LINE   = LINE_IDX_BITS'(NUM_LINES - 1);

   function automatic logic [LINE_IDX_BITS-1:0] line_mod(input logic [LINE_IN_W-1:0] v);
      logic [LINE_IDX_BITS:0] r;
      r = '0;
      for (int i = LINE_IN_W - 1; i >= 0; i--) begin
         r = {r[LINE_IDX_BITS-1:0], v[i]};
         if (r >= NUM_LINES_R) begin
            r = r - NUM_LINES_R;
         end
      end
      return r[LINE_IDX_BITS-1:0];
   endfunction

   logic                     clr_active_ff, clr_active_in;
   logic [LINE_IDX_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   logic                     s1_valid_ff, s1_valid_in;
   op_type                   s1_op_ff;
   logic [LINE_IDX_BITS-1:0] s1_idx_ff;
   logic [ADDR_KEEP-1:0]     s1_addr_ff;
   logic [RID_W-1:0]         s1_rid_ff;
   logic                     s1_shin_ff;

   logic                     fwd_valid_ff, fwd_valid_in;
   logic [LINE_IDX_BITS-1:0] fwd_idx_ff;
   line_state_type           fwd_state_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff;

   logic                     req_accept, out_free, s1_advance;
   logic                     ram_wr_en;
   logic [LINE_IDX_BITS-1:0] ram_wr_addr;
   logic [STATE_W-1:0]       ram_wr_data, ram_rd_data;

   line_state_type           cur_state, next_state;
   err_type                  err;
   logic                     is_store, is_getm;
   logic                     gets, getm, tocpu, tobus, shout, miss, upgrade;
   rsp_type                  rsp_in;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = clr_active_ff || (s1_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   moesif_ram #(
      .WIDTH (STATE_W),
      .DEPTH (NUM_LINES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (line_mod(req_line_index)),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en   = clr_active_ff || s1_advance;
   assign ram_wr_addr = clr_active_ff ? clr_cnt_ff : s1_idx_ff;
   assign ram_wr_data = clr_active_ff ? ST_I : next_state;

   // bypass the write that the RAM read did not see
   assign cur_state = (fwd_valid_ff && (fwd_idx_ff == s1_idx_ff)) ? fwd_state_ff
                                                                 : line_state_type'(ram_rd_data);
   assign is_store  = (s1_op_ff == OP_STORE);
   assign is_getm   = (s1_op_ff == OP_GETM);

   always_comb begin
      next_state = cur_state;
      err        = ERR_NONE;
      unique case (s1_op_ff)
         OP_LOAD, OP_STORE: begin
            unique case (cur_state)
               ST_I: next_state = is_store ? ST_IM : ST_IS;
               ST_E: if (is_store) next_state = ST_M;
               ST_S: if (is_store) next_state = ST_SM;
               ST_O: if (is_store) next_state = ST_OM;
               ST_F: if (is_store) next_state = ST_FM;
               ST_M: ;
               default: err = ERR_OUTSTANDING;
            endcase
         end
         OP_DATA: begin
            unique case (cur_state)
               ST_I, ST_OM, ST_FM: ;
               ST_IS: next_state = s1_shin_ff ? ST_S : ST_E;
               ST_IM, ST_SM: next_state = ST_M;
               default: err = ERR_DATA_OWNED;
            endcase
         end
         OP_GETS, OP_GETM: begin
            unique case (cur_state)
               ST_S, ST_O, ST_F: if (is_getm) next_state = ST_I;
               ST_E: next_state = is_getm ? ST_I : ST_F;
               ST_M: next_state = is_getm ? ST_I : ST_O;
               ST_OM, ST_FM: if (is_getm) next_state = ST_IM;
               default: ;
            endcase
         end
         default: err = ERR_UNEXPECTED;
      endcase
   end

   always_comb begin
      gets    = 1'b0;
      getm    = 1'b0;
      tocpu   = 1'b0;
      tobus   = 1'b0;
      shout   = 1'b0;
      miss    = 1'b0;
      upgrade = 1'b0;
      unique case (s1_op_ff)
         OP_LOAD, OP_STORE: begin
            unique case (cur_state)
               ST_I: begin
                  gets = !is_store;
                  getm = is_store;
                  miss = 1'b1;
               end
               ST_M: tocpu = 1'b1;
               ST_E: begin
                  tocpu   = 1'b1;
                  upgrade = is_store;
               end
               ST_S, ST_O, ST_F: begin
                  tocpu = !is_store;
                  getm  = is_store;
                  miss  = is_store;
               end
               default: ;
            endcase
         end
         OP_DATA: begin
            unique case (cur_state)
               ST_IS, ST_IM, ST_SM: tocpu = 1'b1;
               default: ;
            endcase
         end
         OP_GETS, OP_GETM: begin
            unique case (cur_state)
               ST_S: shout = 1'b1;
               ST_E, ST_M, ST_O, ST_F, ST_FM: begin
                  tobus = 1'b1;
                  shout = 1'b1;
               end
               ST_SM: shout = !is_getm;
               ST_OM: tobus = 1'b1;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_in                      = '0;
      rsp_in.issue_gets           = gets;
      rsp_in.issue_getm           = getm;
      rsp_in.data_to_cpu          = tocpu;
      rsp_in.data_to_bus          = tobus;
      rsp_in.data_dest_id         = tobus ? s1_rid_ff : '0;
      rsp_in.shared_out           = shout;
      rsp_in.address_out          = (gets || getm || tocpu || tobus) ? ADDR_W'(s1_addr_ff) : '0;
      rsp_in.miss_event           = miss;
      rsp_in.silent_upgrade_event = upgrade;
      rsp_in.error_code           = err;
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_LINE) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      if (clr_active_ff) begin
         fwd_valid_in = 1'b0;
      end else if (s1_advance) begin
         fwd_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= op_type'(req_operation);
         s1_idx_ff  <= line_mod(req_line_index);
         s1_addr_ff <= req_address[ADDR_KEEP-1:0];
         s1_rid_ff  <= req_requester_id;
         s1_shin_ff <= req_shared_in;
      end
      if (s1_advance) begin
         rsp_ff       <= rsp_in;
         fwd_idx_ff   <= s1_idx_ff;
         fwd_state_ff <= next_state;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_issue_gets           = rsp_ff.issue_gets;
   assign rsp_issue_getm           = rsp_ff.issue_getm;
   assign rsp_data_to_cpu          = rsp_ff.data_to_cpu;
   assign rsp_data_to_bus          = rsp_ff.data_to_bus;
   assign rsp_data_dest_id         = rsp_ff.data_dest_id;
   assign rsp_shared_out           = rsp_ff.shared_out;
   assign rsp_address_out          = rsp_ff.address_out;
   assign rsp_miss_event           = rsp_ff.miss_event;
   assign rsp_silent_upgrade_event = rsp_ff.silent_upgrade_event;
   assign rsp_error_code           = rsp_ff.error_code;

   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_accept)
      else $error("request accepted during clearing sweep");

   a_advance_gives_response : assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid)
      else $error("completed request produced no response");

   a_error_response_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != ERR_NONE)) |->
         !(rsp_issue_gets || rsp_issue_getm || rsp_data_to_cpu || rsp_data_to_bus ||
           rsp_shared_out || rsp_miss_event || rsp_silent_upgrade_event))
      else $error("error response carries actions");

   a_single_bus_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_issue_gets && rsp_issue_getm))
      else $error("GETS and GETM issued together");

   a_stage_held_when_blocked : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_idx_ff)))
      else $error("blocked request lost its line");

endmodule

`default_nettype wire

@@ dv/moesif_line_checker.sv @@
`timescale 1ns / 1ps

module moesif_line_checker
   import moesif_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,

   input  wire                 req_valid,
   input  wire                 req_stall,
   input  wire [OP_W-1:0]      req_operation,
   input  wire [LINE_IN_W-1:0] req_line_index,
   input  wire [ADDR_W-1:0]    req_address,
   input  wire [RID_W-1:0]     req_requester_id,
   input  wire                 req_shared_in,

   input  wire                 rsp_valid,
   input  wire                 rsp_stall,
   input  wire                 rsp_issue_gets,
   input  wire                 rsp_issue_getm,
   input  wire                 rsp_data_to_cpu,
   input  wire                 rsp_data_to_bus,
   input  wire [RID_W-1:0]     rsp_data_dest_id,
   input  wire                 rsp_shared_out,
   input  wire [ADDR_W-1:0]    rsp_address_out,
   input  wire                 rsp_miss_event,
   input  wire                 rsp_silent_upgrade_event,
   input  wire [1:0]           rsp_error_code,

   output int                  mismatch_count,
   output int                  pending_count
);

   localparam int TRACKED_LINES = 256;

   line_state_type line_states [TRACKED_LINES];
   rsp_type        awaited_responses [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic rsp_type apply_coherence(input logic [OP_W-1:0]      op,
                                                input logic [LINE_IN_W-1:0] idx,
                                                input logic [ADDR_W-1:0]    addr,
                                                input logic [RID_W-1:0]     rid,
                                                input logic                 shin);
      line_state_type cur;
      line_state_type nxt;
      rsp_type        outcome;
      err_type        fault;
      logic           is_store;
      logic           is_getm;
      cur      = line_states[idx % TRACKED_LINES];
      nxt      = cur;
      outcome  = '0;
      fault    = ERR_NONE;
      is_store = (op == OP_STORE);
      is_getm  = (op == OP_GETM);
      case (op)
         OP_LOAD, OP_STORE: begin
            if (cur >= ST_IS) begin
               fault = ERR_OUTSTANDING;
            end else if (cur == ST_I) begin
               outcome.miss_event = 1'b1;
               if (is_store) begin
                  outcome.issue_getm = 1'b1;
                  nxt = ST_IM;
               end else begin
                  outcome.issue_gets = 1'b1;
                  nxt = ST_IS;
               end
            end else if (cur == ST_M) begin
               outcome.data_to_cpu = 1'b1;
            end else if (cur == ST_E) begin
               outcome.data_to_cpu = 1'b1;
               if (is_store) begin
                  nxt = ST_M;
                  outcome.silent_upgrade_event = 1'b1;
               end
            end else if (!is_store) begin
               outcome.data_to_cpu = 1'b1;
            end else begin
               outcome.issue_getm = 1'b1;
               outcome.miss_event = 1'b1;
               if (cur == ST_S) nxt = ST_SM;
               else if (cur == ST_O) nxt = ST_OM;
               else nxt = ST_FM;
            end
         end
         OP_DATA: begin
            case (cur)
               ST_I, ST_OM, ST_FM: ;
               ST_IS: begin
                  outcome.data_to_cpu = 1'b1;
                  if (shin) nxt = ST_S;
                  else nxt = ST_E;
               end
               ST_IM, ST_SM: begin
                  outcome.data_to_cpu = 1'b1;
                  nxt = ST_M;
               end
               default: fault = ERR_DATA_OWNED;
            endcase
         end
         OP_GETS, OP_GETM: begin
            case (cur)
               ST_S: begin
                  outcome.shared_out = 1'b1;
                  if (is_getm) nxt = ST_I;
               end
               ST_E: begin
                  outcome.data_to_bus = 1'b1;
                  outcome.shared_out  = 1'b1;
                  if (is_getm) nxt = ST_I;
                  else nxt = ST_F;
               end
               ST_M: begin
                  outcome.data_to_bus = 1'b1;
                  outcome.shared_out  = 1'b1;
                  if (is_getm) nxt = ST_I;
                  else nxt = ST_O;
               end
               ST_O, ST_F: begin
                  outcome.data_to_bus = 1'b1;
                  outcome.shared_out  = 1'b1;
                  if (is_getm) nxt = ST_I;
               end
               ST_SM: begin
                  if (!is_getm) outcome.shared_out = 1'b1;
               end
               ST_OM: begin
                  outcome.data_to_bus = 1'b1;
                  if (is_getm) nxt = ST_IM;
               end
               ST_FM: begin
                  outcome.data_to_bus = 1'b1;
                  outcome.shared_out  = 1'b1;
                  if (is_getm) nxt = ST_IM;
               end
               default: ;
            endcase
         end
         default: fault = ERR_UNEXPECTED;
      endcase

      if (fault != ERR_NONE) begin
         outcome = '0;
         outcome.error_code = fault;
      end else begin
         line_states[idx % TRACKED_LINES] = nxt;
         if (outcome.data_to_bus) outcome.data_dest_id = rid;
         if (outcome.issue_gets || outcome.issue_getm || outcome.data_to_cpu ||
             outcome.data_to_bus)
            outcome.address_out = addr;
      end
      return outcome;
   endfunction

   task automatic compare_field(input string            field,
                                input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (line_states[i]) line_states[i] = ST_I;
         awaited_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = awaited_responses.pop_front();
               compare_field("issue_gets", ADDR_W'(want.issue_gets), ADDR_W'(rsp_issue_gets));
               compare_field("issue_getm", ADDR_W'(want.issue_getm), ADDR_W'(rsp_issue_getm));
               compare_field("data_to_cpu", ADDR_W'(want.data_to_cpu),
                             ADDR_W'(rsp_data_to_cpu));
               compare_field("data_to_bus", ADDR_W'(want.data_to_bus),
                             ADDR_W'(rsp_data_to_bus));
               compare_field("data_dest_id", ADDR_W'(want.data_dest_id),
                             ADDR_W'(rsp_data_dest_id));
               compare_field("shared_out", ADDR_W'(want.shared_out), ADDR_W'(rsp_shared_out));
               compare_field("address_out", want.address_out, rsp_address_out);
               compare_field("miss_event", ADDR_W'(want.miss_event), ADDR_W'(rsp_miss_event));
               compare_field("silent_upgrade_event", ADDR_W'(want.silent_upgrade_event),
                             ADDR_W'(rsp_silent_upgrade_event));
               compare_field("error_code", ADDR_W'(want.error_code), ADDR_W'(rsp_error_code));
            end
         end
         if (req_valid && !req_stall)
            awaited_responses.push_back(apply_coherence(req_operation, req_line_index,
                                                        req_address, req_requester_id,
                                                        req_shared_in));
      end
      pending_count = awaited_responses.size();
   end

endmodule

@@ dv/tb_moesif_line_coherence_fsm.sv @@
`timescale 1ns / 1ps

module tb_moesif_line_coherence_fsm;
   import moesif_pkg::*;

   localparam logic [OP_W-1:0] OP_BAD_LO   = 3'd5;
   localparam logic [OP_W-1:0] OP_BAD_HI   = 3'd7;
   localparam int              STUCK_LIMIT = 2000;
   localparam int              HOLD_CYCLES = 160;
   localparam int              DRAIN_CYCLES = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation = '0;
   logic [LINE_IN_W-1:0] req_line_index = '0;
   logic [ADDR_W-1:0]    req_address = '0;
   logic [RID_W-1:0]     req_requester_id = '0;
   logic                 req_shared_in = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_issue_gets;
   logic                 rsp_issue_getm;
   logic                 rsp_data_to_cpu;
   logic                 rsp_data_to_bus;
   logic [RID_W-1:0]     rsp_data_dest_id;
   logic                 rsp_shared_out;
   logic [ADDR_W-1:0]    rsp_address_out;
   logic                 rsp_miss_event;
   logic                 rsp_silent_upgrade_event;
   logic [1:0]           rsp_error_code;

   int mismatch_count;
   int pending_count;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holds_asked   = 0;
   int stuck_cycles  = 0;

   moesif_line_coherence_fsm dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_operation            (req_operation),
      .req_line_index           (req_line_index),
      .req_address              (req_address),
      .req_requester_id         (req_requester_id),
      .req_shared_in            (req_shared_in),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_issue_gets           (rsp_issue_gets),
      .rsp_issue_getm           (rsp_issue_getm),
      .rsp_data_to_cpu          (rsp_data_to_cpu),
      .rsp_data_to_bus          (rsp_data_to_bus),
      .rsp_data_dest_id         (rsp_data_dest_id),
      .rsp_shared_out           (rsp_shared_out),
      .rsp_address_out          (rsp_address_out),
      .rsp_miss_event           (rsp_miss_event),
      .rsp_silent_upgrade_event (rsp_silent_upgrade_event),
      .rsp_error_code           (rsp_error_code)
   );

   moesif_line_checker coherence_check (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_operation            (req_operation),
      .req_line_index           (req_line_index),
      .req_address              (req_address),
      .req_requester_id         (req_requester_id),
      .req_shared_in            (req_shared_in),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_issue_gets           (rsp_issue_gets),
      .rsp_issue_getm           (rsp_issue_getm),
      .rsp_data_to_cpu          (rsp_data_to_cpu),
      .rsp_data_to_bus          (rsp_data_to_bus),
      .rsp_data_dest_id         (rsp_data_dest_id),
      .rsp_shared_out           (rsp_shared_out),
      .rsp_address_out          (rsp_address_out),
      .rsp_miss_event           (rsp_miss_event),
      .rsp_silent_upgrade_event (rsp_silent_upgrade_event),
      .rsp_error_code           (rsp_error_code),
      .mismatch_count           (mismatch_count),
      .pending_count            (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // hold off the response side when asked, otherwise stall at random
   initial begin
      int holds_served;
      int hold_left;
      holds_served = 0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
      end
      $display("tb_moesif_line_coherence_fsm: errors");
      $finish;
   end

   task automatic send(input logic [OP_W-1:0]      op,
                       input logic [LINE_IN_W-1:0] idx,
                       input logic [ADDR_W-1:0]    addr,
                       input logic [RID_W-1:0]     rid,
                       input logic                 shin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_line_index   <= idx;
      req_address      <= addr;
      req_requester_id <= rid;
      req_shared_in    <= shin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_random(input logic [OP_W-1:0] op, input logic [LINE_IN_W-1:0] idx);
      send(op, idx, $urandom(), RID_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endtask

   // mostly a processor access, a few snoops from other nodes, then the fill
   task automatic coherence_traffic(input int count);
      int                   sent;
      int                   snoops;
      logic [LINE_IN_W-1:0] idx;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) idx = LINE_IN_W'($urandom_range(0, 255));
         else idx = LINE_IN_W'($urandom_range(0, 7));
         if ($urandom_range(0, 9) < 7) begin
            snoops = $urandom_range(0, 2);
            send_random($urandom_range(0, 1) ? OP_STORE : OP_LOAD, idx);
            repeat (snoops) send_random($urandom_range(0, 1) ? OP_GETM : OP_GETS, idx);
            send_random(OP_DATA, idx);
            sent += snoops + 2;
         end else begin
            send_random(OP_W'($urandom_range(0, 7)), idx);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send(OP_LOAD,  8'd0, 32'h0000_0000, 4'd0,  1'b0);
      send(OP_LOAD,  8'd0, 32'h0000_0004, 4'd1,  1'b1);
      send(OP_GETS,  8'd0, 32'h0000_0008, 4'd2,  1'b0);
      send(OP_DATA,  8'd0, 32'h0000_000c, 4'd3,  1'b0);
      send(OP_STORE, 8'd0, 32'h1234_5678, 4'd4,  1'b0);
      send(OP_GETS,  8'd0, 32'h8765_4321, 4'd15, 1'b0);
      send(OP_STORE, 8'd0, 32'h0000_0010, 4'd5,  1'b0);
      send(OP_DATA,  8'd0, 32'h0000_0014, 4'd6,  1'b1);
      send(OP_GETM,  8'd0, 32'h0000_0018, 4'd7,  1'b0);
      send(OP_DATA,  8'd0, 32'h0000_001c, 4'd8,  1'b0);
      send(OP_DATA,  8'd0, 32'h0000_0020, 4'd9,  1'b0);
      send(OP_GETM,  8'd0, 32'h0000_0024, 4'd10, 1'b0);
      send(OP_DATA,  8'd0, 32'h0000_0028, 4'd11, 1'b0);
      send(OP_LOAD,  8'd255, 32'hffff_ffff, 4'd15, 1'b1);
      send(OP_DATA,  8'd255, 32'hffff_ffff, 4'd15, 1'b1);
      send(OP_STORE, 8'd255, 32'hffff_ffff, 4'd15, 1'b1);
      send(OP_GETS,  8'd255, 32'hffff_ffff, 4'd12, 1'b1);
      send(OP_GETM,  8'd255, 32'hffff_ffff, 4'd13, 1'b1);
      send(OP_DATA,  8'd255, 32'hffff_ffff, 4'd14, 1'b1);
      send(OP_LOAD,  8'd2, 32'haaaa_5555, 4'd0,  1'b0);
      send(OP_DATA,  8'd2, 32'h5555_aaaa, 4'd1,  1'b0);
      send(OP_GETS,  8'd2, 32'h0f0f_0f0f, 4'd2,  1'b0);
      send(OP_STORE, 8'd2, 32'hf0f0_f0f0, 4'd3,  1'b0);
      send(OP_GETM,  8'd2, 32'h0000_0100, 4'd4,  1'b0);
      send(OP_BAD_LO, 8'd3, 32'hffff_ffff, 4'd15, 1'b1);
      send(OP_BAD_HI, 8'd3, 32'hffff_ffff, 4'd15, 1'b1);

      coherence_traffic(450);
      send_idle_pct = 80;
      coherence_traffic(400);
      send_idle_pct = 0;
      stall_pct     = 80;
      coherence_traffic(400);
      send_idle_pct = 23;
      stall_pct     = 23;
      coherence_traffic(400);

      // back up the pipeline behind a long response hold-off
      send_idle_pct = 0;
      stall_pct     = 0;
      holds_asked++;
      coherence_traffic(200);

      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("tb_moesif_line_coherence_fsm: clean");
      else
         $display("tb_moesif_line_coherence_fsm: errors");
      $finish;
   end

endmodule

@@ moesif_line_coherence_fsm.f @@
hw/rtl/moesif_pkg.sv
hw/rtl/moesif_ram.sv
hw/rtl/moesif_line_coherence_fsm.sv
dv/moesif_line_checker.sv
dv/tb_moesif_line_coherence_fsm.sv
